/* src/mntts_pkg.sv */
// Package for the MIDI note to tone segment block.
// Holds the note-to-frequency table, the segment stage phases and the item
// struct passed between the event stage and the segment stage. No dependencies.
package mntts_pkg;

   localparam int unsigned NOTE_W  = 7;
   localparam int unsigned TICKS_W = 28;
   localparam int unsigned MPT_W   = 26;
   localparam int unsigned FREQ_W  = 14;
   localparam int unsigned DUR_W   = 16;
   localparam int unsigned PROD_W  = TICKS_W + MPT_W;
   localparam int unsigned FRAC_W  = 16;

   localparam logic [MPT_W-1:0] MPT_RESET   = MPT_W'(68267);
   localparam logic [DUR_W-1:0] DUR_SAT_MAX = '1;

   // floor(8.175798916 * 2^(n/12)) Hz for each MIDI note number.
   localparam logic [FREQ_W-1:0] TONE_TABLE [128] = '{
      14'd8,     14'd8,     14'd9,     14'd9,     14'd10,    14'd10,
      14'd11,    14'd12,    14'd12,    14'd13,    14'd14,    14'd15,
      14'd16,    14'd17,    14'd18,    14'd19,    14'd20,    14'd21,
      14'd23,    14'd24,    14'd25,    14'd27,    14'd29,    14'd30,
      14'd32,    14'd34,    14'd36,    14'd38,    14'd41,    14'd43,
      14'd46,    14'd48,    14'd51,    14'd55,    14'd58,    14'd61,
      14'd65,    14'd69,    14'd73,    14'd77,    14'd82,    14'd87,
      14'd92,    14'd97,    14'd103,   14'd110,   14'd116,   14'd123,
      14'd130,   14'd138,   14'd146,   14'd155,   14'd164,   14'd174,
      14'd184,   14'd195,   14'd207,   14'd220,   14'd233,   14'd246,
      14'd261,   14'd277,   14'd293,   14'd311,   14'd329,   14'd349,
      14'd369,   14'd391,   14'd415,   14'd440,   14'd466,   14'd493,
      14'd523,   14'd554,   14'd587,   14'd622,   14'd659,   14'd698,
      14'd739,   14'd783,   14'd830,   14'd880,   14'd932,   14'd987,
      14'd1046,  14'd1108,  14'd1174,  14'd1244,  14'd1318,  14'd1396,
      14'd1479,  14'd1567,  14'd1661,  14'd1760,  14'd1864,  14'd1975,
      14'd2093,  14'd2217,  14'd2349,  14'd2489,  14'd2637,  14'd2793,
      14'd2959,  14'd3135,  14'd3322,  14'd3520,  14'd3729,  14'd3951,
      14'd4186,  14'd4434,  14'd4698,  14'd4978,  14'd5274,  14'd5587,
      14'd5919,  14'd6271,  14'd6644,  14'd7040,  14'd7458,  14'd7902,
      14'd8372,  14'd8869,  14'd9397,  14'd9956,  14'd10548, 14'd11175,
      14'd11839, 14'd12543
   };

   typedef enum logic [1:0] {
      PH_SEGMENT,
      PH_FLUSH,
      PH_TERMINATE
   } phase_type;

   typedef struct packed {
      logic [FREQ_W-1:0] frequency;
      logic [DUR_W-1:0]  duration;
      logic              has_ticks;
      logic              end_mark;
   } seg_item_type;

endpackage

/* src/mntts_event_stage.sv */
// Event stage: input register, frequency lookup and tick-to-ms multiply.
// Depends on mntts_pkg for the tone table, widths and the item struct.
module mntts_event_stage
   import mntts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [NOTE_W-1:0]  req_note_number,
   input  logic               req_note_on,
   input  logic [TICKS_W-1:0] req_ticks_to_next,
   input  logic               req_end_of_sequence,
   input  logic [MPT_W-1:0]   ms_per_tick,
   output logic               item_valid,
   input  logic               item_stall,
   output seg_item_type       item
);

   logic               valid_ff, valid_in;
   logic [NOTE_W-1:0]  note_ff;
   logic               on_ff;
   logic [TICKS_W-1:0] ticks_ff;
   logic               end_ff;
   logic               accept;
   logic [PROD_W-1:0]  product;

   assign req_stall = valid_ff && item_stall;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && item_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         note_ff  <= req_note_number;
         on_ff    <= req_note_on;
         ticks_ff <= req_ticks_to_next;
         end_ff   <= req_end_of_sequence;
      end
   end

   assign product = PROD_W'(ticks_ff) * PROD_W'(ms_per_tick);

   always_comb begin
      item.frequency = on_ff ? TONE_TABLE[note_ff] : '0;
      // Anything above the 16 integer bits kept saturates the duration.
      if (product[PROD_W-1:FRAC_W+DUR_W] != '0) begin
         item.duration = DUR_SAT_MAX;
      end else begin
         item.duration = product[FRAC_W+DUR_W-1:FRAC_W];
      end
      item.has_ticks = (ticks_ff != '0);
      item.end_mark  = end_ff;
   end

   assign item_valid = valid_ff;

endmodule

/* src/mntts_segment_ctrl.sv */
// Segment stage: holds the pending segment, merges equal frequencies and
// sequences flush and terminator results into the output register.
// Depends on mntts_pkg for the phase enum and the item struct.
module mntts_segment_ctrl
   import mntts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_stall,
   input  seg_item_type      item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DUR_W-1:0]  rsp_duration_ms,
   output logic [FREQ_W-1:0] rsp_frequency_hz,
   output logic              rsp_last_segment
);

   logic              cur_valid_ff, cur_valid_in;
   seg_item_type      cur_ff;
   phase_type         phase_ff, phase_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [FREQ_W-1:0] pend_freq_ff, pend_freq_in;
   logic [DUR_W-1:0]  pend_dur_ff, pend_dur_in;
   logic              out_valid_ff, out_valid_in;
   logic [DUR_W-1:0]  out_dur_ff;
   logic [FREQ_W-1:0] out_freq_ff;
   logic              out_last_ff;

   logic              emit;
   logic [DUR_W-1:0]  emit_dur;
   logic [FREQ_W-1:0] emit_freq;
   logic              emit_last;
   logic              final_step;
   logic              out_free;
   logic              step_go;
   logic              item_done;
   logic              load;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step_go   = cur_valid_ff && (!emit || out_free);
   assign item_done = step_go && final_step;
   assign item_stall = cur_valid_ff && !item_done;
   assign load      = item_valid && !item_stall;
   assign cur_valid_in = load || (cur_valid_ff && !item_done);

   // What the current step emits and how it changes the pending segment.
   always_comb begin
      emit          = 1'b0;
      emit_dur      = '0;
      emit_freq     = '0;
      emit_last     = 1'b0;
      final_step    = 1'b0;
      pend_valid_in = pend_valid_ff;
      pend_freq_in  = pend_freq_ff;
      pend_dur_in   = pend_dur_ff;
      unique case (phase_ff)
         PH_SEGMENT: begin
            if (cur_ff.has_ticks) begin
               if (pend_valid_ff && (cur_ff.frequency == pend_freq_ff)) begin
                  pend_dur_in = pend_dur_ff + cur_ff.duration;
               end else begin
                  emit          = pend_valid_ff;
                  emit_dur      = pend_dur_ff;
                  emit_freq     = pend_freq_ff;
                  pend_valid_in = 1'b1;
                  pend_freq_in  = cur_ff.frequency;
                  pend_dur_in   = cur_ff.duration;
               end
            end
            final_step = !cur_ff.end_mark;
         end
         PH_FLUSH: begin
            emit          = pend_valid_ff;
            emit_dur      = pend_dur_ff;
            emit_freq     = pend_freq_ff;
            pend_valid_in = 1'b0;
            pend_freq_in  = '0;
            pend_dur_in   = '0;
         end
         PH_TERMINATE: begin
            emit       = 1'b1;
            emit_last  = 1'b1;
            final_step = 1'b1;
         end
         default: begin
            final_step = 1'b1;
         end
      endcase
   end

   // Next phase; every item starts and ends in the segment phase.
   always_comb begin
      phase_in = phase_ff;
      if (step_go) begin
         if (final_step) begin
            phase_in = PH_SEGMENT;
         end else begin
            unique case (phase_ff)
               PH_SEGMENT: phase_in = PH_FLUSH;
               PH_FLUSH:   phase_in = PH_TERMINATE;
               default:    phase_in = PH_SEGMENT;
            endcase
         end
      end
   end

   assign out_valid_in = (step_go && emit) || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff  <= 1'b0;
         phase_ff      <= PH_SEGMENT;
         pend_valid_ff <= 1'b0;
         pend_freq_ff  <= '0;
         pend_dur_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
         if (step_go) begin
            pend_valid_ff <= pend_valid_in;
            pend_freq_ff  <= pend_freq_in;
            pend_dur_ff   <= pend_dur_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= item;
      end
      if (step_go && emit) begin
         out_dur_ff  <= emit_dur;
         out_freq_ff <= emit_freq;
         out_last_ff <= emit_last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_duration_ms  = out_dur_ff;
   assign rsp_frequency_hz = out_freq_ff;
   assign rsp_last_segment = out_last_ff;

endmodule

/* src/midi_note_to_tone_segments.sv */
// Path: a result passes the input register, the segment stage's current-item
// register and the output register once accepted, when the output is free.
// Throughput: one transaction per cycle while nothing stalls; an end-marked
// event holds the segment stage through its segment, flush and terminator steps.
// Reset: synchronous; empties the pipeline, clears the pending segment and
// sets the ms-per-tick register to 68267.
module midi_note_to_tone_segments
   import mntts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [MPT_W-1:0]   csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [NOTE_W-1:0]  req_note_number,
   input  logic               req_note_on,
   input  logic [TICKS_W-1:0] req_ticks_to_next,
   input  logic               req_end_of_sequence,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DUR_W-1:0]   rsp_duration_ms,
   output logic [FREQ_W-1:0]  rsp_frequency_hz,
   output logic               rsp_last_segment
);

   logic [MPT_W-1:0] ms_per_tick_ff;
   logic             item_valid;
   logic             item_stall;
   seg_item_type     item;

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_per_tick_ff <= MPT_RESET;
      end else if (csr_write_enable) begin
         ms_per_tick_ff <= csr_write_data;
      end
   end

   mntts_event_stage u_event_stage (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_note_number     (req_note_number),
      .req_note_on         (req_note_on),
      .req_ticks_to_next   (req_ticks_to_next),
      .req_end_of_sequence (req_end_of_sequence),
      .ms_per_tick         (ms_per_tick_ff),
      .item_valid          (item_valid),
      .item_stall          (item_stall),
      .item                (item)
   );

   mntts_segment_ctrl u_segment_ctrl (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item_stall       (item_stall),
      .item             (item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_duration_ms  (rsp_duration_ms),
      .rsp_frequency_hz (rsp_frequency_hz),
      .rsp_last_segment (rsp_last_segment)
   );

endmodule

/* tb/tb_midi_note_to_tone_segments.sv */
`timescale 1ns / 100ps
// Self-checking testbench for midi_note_to_tone_segments: directed events, then random
// note sequences under several ms-per-tick settings and idle patterns.
// Depends on mntts_pkg and the midi_note_to_tone_segments RTL.
module tb_midi_note_to_tone_segments;
   import mntts_pkg::*;

   typedef struct packed {
      logic [DUR_W-1:0]  duration_ms;
      logic [FREQ_W-1:0] frequency_hz;
      logic              last_segment;
   } segment_type;

   localparam segment_type NO_SEG     = '0;
   localparam segment_type TERMINATOR = '{16'd0, 14'd0, 1'b1};

   // One note event. Rows with has_literal set carry their results written out by hand.
   typedef struct packed {
      logic [NOTE_W-1:0]     note_number;
      logic                  note_on;
      logic [TICKS_W-1:0]    ticks;
      logic                  end_mark;
      logic                  has_literal;
      logic [1:0]            n_literal;
      segment_type [0:2]     literal_segs;
   } note_event_type;

   localparam logic [TICKS_W-1:0] TICKS_MAX = '1;

   localparam note_event_type DIRECTED [17] = '{
      // End mark with zero ticks and nothing held: only the terminator.
      '{7'd69,  1'b1, 28'd0,        1'b1, 1'b1, 2'd1, '{TERMINATOR, NO_SEG, NO_SEG}},
      '{7'd127, 1'b1, TICKS_MAX,    1'b0, 1'b1, 2'd0, '0},
      // Both segments saturate at the largest tick count.
      '{7'd0,   1'b1, TICKS_MAX,    1'b1, 1'b1, 2'd3,
        '{'{16'hFFFF, 14'd12543, 1'b0}, '{16'hFFFF, 14'd8, 1'b0}, TERMINATOR}},
      '{7'd0,   1'b0, 28'd16,       1'b0, 1'b0, 2'd0, '0},
      '{7'd127, 1'b0, 28'd100,      1'b0, 1'b0, 2'd0, '0},
      '{7'd1,   1'b1, 28'd0,        1'b0, 1'b0, 2'd0, '0},
      '{7'd0,   1'b1, 28'd1000,     1'b0, 1'b0, 2'd0, '0},
      '{7'd1,   1'b1, 28'd1000,     1'b0, 1'b0, 2'd0, '0},
      '{7'd2,   1'b1, 28'd500,      1'b0, 1'b0, 2'd0, '0},
      '{7'd3,   1'b1, 28'd0,        1'b1, 1'b0, 2'd0, '0},
      '{7'd60,  1'b1, TICKS_MAX,    1'b0, 1'b0, 2'd0, '0},
      '{7'd60,  1'b1, TICKS_MAX,    1'b0, 1'b0, 2'd0, '0},
      '{7'd60,  1'b1, 28'd1,        1'b1, 1'b0, 2'd0, '0},
      '{7'h55,  1'b1, 28'h5555555,  1'b0, 1'b0, 2'd0, '0},
      '{7'h2A,  1'b1, 28'hAAAAAAA,  1'b1, 1'b0, 2'd0, '0},
      '{7'd100, 1'b0, 28'd7,        1'b1, 1'b0, 2'd0, '0},
      '{7'd127, 1'b0, 28'd0,        1'b0, 1'b0, 2'd0, '0}
   };

   localparam logic [FREQ_W-1:0] NOTE_HZ [128] = '{
      8, 8, 9, 9, 10, 10, 11, 12, 12, 13, 14, 15,
      16, 17, 18, 19, 20, 21, 23, 24, 25, 27, 29, 30,
      32, 34, 36, 38, 41, 43, 46, 48, 51, 55, 58, 61,
      65, 69, 73, 77, 82, 87, 92, 97, 103, 110, 116, 123,
      130, 138, 146, 155, 164, 174, 184, 195, 207, 220, 233, 246,
      261, 277, 293, 311, 329, 349, 369, 391, 415, 440, 466, 493,
      523, 554, 587, 622, 659, 698, 739, 783, 830, 880, 932, 987,
      1046, 1108, 1174, 1244, 1318, 1396, 1479, 1567, 1661, 1760, 1864, 1975,
      2093, 2217, 2349, 2489, 2637, 2793, 2959, 3135, 3322, 3520, 3729, 3951,
      4186, 4434, 4698, 4978, 5274, 5587, 5919, 6271, 6644, 7040, 7458, 7902,
      8372, 8869, 9397, 9956, 10548, 11175, 11839, 12543
   };

   logic                clock;
   logic                reset               = 1'b1;
   logic                csr_write_enable    = 1'b0;
   logic [MPT_W-1:0]    csr_write_data      = '0;
   logic                req_valid           = 1'b0;
   logic                req_stall;
   logic [NOTE_W-1:0]   req_note_number     = '0;
   logic                req_note_on         = 1'b0;
   logic [TICKS_W-1:0]  req_ticks_to_next   = '0;
   logic                req_end_of_sequence = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall           = 1'b0;
   logic [DUR_W-1:0]    rsp_duration_ms;
   logic [FREQ_W-1:0]   rsp_frequency_hz;
   logic                rsp_last_segment;

   // Shadow of the block's register and held segment.
   logic [MPT_W-1:0]    tick_scale = MPT_RESET;
   logic                held_valid = 1'b0;
   logic [FREQ_W-1:0]   held_hz    = '0;
   logic [DUR_W-1:0]    held_ms    = '0;

   segment_type         segments_due [$];
   int                  mismatches     = 0;
   int                  send_idle_pct  = 0;
   int                  recv_stall_pct = 0;

   midi_note_to_tone_segments i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_note_number     (req_note_number),
      .req_note_on         (req_note_on),
      .req_ticks_to_next   (req_ticks_to_next),
      .req_end_of_sequence (req_end_of_sequence),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_duration_ms     (rsp_duration_ms),
      .rsp_frequency_hz    (rsp_frequency_hz),
      .rsp_last_segment    (rsp_last_segment)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Applies one event to the shadow state and returns the segments it releases.
   function automatic int build_segments(input note_event_type ev,
                                         output segment_type [0:2] segs);
      logic [FREQ_W-1:0] hz;
      logic [PROD_W-1:0] product;
      logic [DUR_W-1:0]  ms;
      int                n;
      n = 0;
      segs = '0;
      if (ev.ticks != 0) begin
         hz = ev.note_on ? NOTE_HZ[ev.note_number] : '0;
         product = ev.ticks * tick_scale;
         ms = (|product[PROD_W-1:32]) ? 16'hFFFF : product[31:16];
         if (held_valid && hz == held_hz) begin
            held_ms = held_ms + ms;
         end else begin
            if (held_valid) begin
               segs[n] = '{held_ms, held_hz, 1'b0};
               n++;
            end
            held_valid = 1'b1;
            held_hz    = hz;
            held_ms    = ms;
         end
      end
      if (ev.end_mark) begin
         if (held_valid) begin
            segs[n] = '{held_ms, held_hz, 1'b0};
            n++;
         end
         segs[n] = TERMINATOR;
         n++;
         held_valid = 1'b0;
         held_hz    = '0;
         held_ms    = '0;
      end
      return n;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_event(input note_event_type ev);
      segment_type [0:2] segs;
      int                n;
      int                k;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_note_number     <= ev.note_number;
      req_note_on         <= ev.note_on;
      req_ticks_to_next   <= ev.ticks;
      req_end_of_sequence <= ev.end_mark;
      do @(posedge clock); while (req_stall);
      n = build_segments(ev, segs);
      if (ev.has_literal) begin
         n    = int'(ev.n_literal);
         segs = ev.literal_segs;
      end
      for (k = 0; k < n; k++) segments_due.push_back(segs[k]);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin : check_segments
      segment_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (segments_due.size() == 0) begin
            $error("unexpected segment: duration_ms %0d frequency_hz %0d last_segment %0d",
                   rsp_duration_ms, rsp_frequency_hz, rsp_last_segment);
            mismatches++;
         end else begin
            want = segments_due.pop_front();
            if (rsp_duration_ms !== want.duration_ms) begin
               $error("duration_ms: expected %0d, got %0d",
                      want.duration_ms, rsp_duration_ms);
               mismatches++;
            end
            if (rsp_frequency_hz !== want.frequency_hz) begin
               $error("frequency_hz: expected %0d, got %0d",
                      want.frequency_hz, rsp_frequency_hz);
               mismatches++;
            end
            if (rsp_last_segment !== want.last_segment) begin
               $error("last_segment: expected %0d, got %0d",
                      want.last_segment, rsp_last_segment);
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      note_event_type    ev;
      logic [NOTE_W-1:0] last_note;
      logic [MPT_W-1:0]  scale_next;
      int                phase;
      int                counted;
      int                seq_left;
      int                pick;
      int                k;
      last_note      = '0;
      seq_left       = 0;
      send_idle_pct  = 26;
      recv_stall_pct = 85;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      for (k = 0; k < $size(DIRECTED); k++) send_event(DIRECTED[k]);

      for (phase = 0; phase < 6; phase++) begin
         send_idle_pct  = (phase < 2) ? 26 : (phase < 4) ? 85 : 0;
         recv_stall_pct = (phase < 2) ? 85 : (phase < 4) ? 26 : 0;
         case (phase)
            0:       scale_next = MPT_W'(65536);
            1:       scale_next = '0;
            2:       scale_next = '1;
            3:       scale_next = MPT_W'($urandom_range(1 << 20, 1));
            4:       scale_next = MPT_W'($urandom());
            default: scale_next = MPT_RESET;
         endcase
         // The register may only change with the pipeline empty, including events
         // that produce no segment.
         req_valid <= 1'b0;
         while (segments_due.size() != 0) @(negedge clock);
         repeat (8) @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_write_data   <= scale_next;
         @(negedge clock);
         csr_write_enable <= 1'b0;
         tick_scale = scale_next;

         counted = 0;
         while (counted < 80) begin
            if (seq_left == 0) seq_left = $urandom_range(8, 1);
            ev = '0;
            pick = $urandom_range(99);
            if (pick < 30) begin
               ev.note_number = last_note;
               ev.note_on     = 1'b1;
            end else begin
               ev.note_number = NOTE_W'($urandom_range(127));
               ev.note_on     = (pick >= 45);
            end
            pick = $urandom_range(99);
            if (pick < 10)
               ev.ticks = '0;
            else if (pick < 20)
               ev.ticks = TICKS_W'($urandom());
            else if (pick < 30)
               ev.ticks = TICKS_W'($urandom_range(65535, 1));
            else
               ev.ticks = TICKS_W'($urandom_range(2000, 1));
            seq_left--;
            // Most sequences close with an end mark; a few run on or end early.
            if (seq_left == 0)
               ev.end_mark = ($urandom_range(99) >= 10);
            else
               ev.end_mark = ($urandom_range(99) < 3);
            last_note = ev.note_number;
            send_event(ev);
            counted++;
         end
      end

      req_valid <= 1'b0;
      while (segments_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* filelist.f */
src/mntts_pkg.sv
src/mntts_event_stage.sv
src/mntts_segment_ctrl.sv
src/midi_note_to_tone_segments.sv
tb/tb_midi_note_to_tone_segments.sv
